[sv/gelu_fb_pkg.sv]
// Package for the GELU forward/backward core: fixed-point constants, mode codes,
// the tanh table builder and the stage-advance bundle for the tanh unit.
// No dependencies; the tanh unit, the core, the checker and the testbench import it.
`default_nettype none

package gelu_fb_pkg;

    // Fixed-point coefficients
    localparam logic [15:0] SQRT_2_PI_Q16 = 16'd52290;  // sqrt(2/pi), Q.16
    localparam logic [11:0] CUBIC_Q16     = 12'd2930;   // 0.044715, Q.16
    localparam logic [13:0] CUBIC3_Q16    = 14'd8791;   // 3*0.044715, Q.16
    localparam logic [16:0] U_LIMIT_Q12   = 17'd16384;  // 4.0, Q.12
    localparam logic [15:0] X_CAP_Q12     = 16'h8000;   // 8.0, Q.12
    localparam logic [15:0] TANH_ONE_Q15  = 16'h8000;   // 1.0, Q.15
    localparam logic [16:0] HALF_Q16      = 17'd32768;  // 0.5, Q.16

    typedef enum logic
    {
        MODE_FORWARD  = 1'b0,
        MODE_BACKWARD = 1'b1
    } mode_t;

    // Load enables of the three tanh stages
    typedef struct packed
    {
        logic idx;
        logic tab;
        logic ta;
    } tanh_adv_t;

    // Restoring division, used only while the table is built at elaboration
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(4k/n) in unsigned Q.15 by exp series, reciprocal and repeated squaring
    function automatic logic [15:0] tanh_entry(input int unsigned k, input int unsigned n);
        logic [63:0] one;
        logic [63:0] z;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] q;
        one  = 64'd1 << 30;
        z    = udiv64(64'(k) << 29, 64'(n));
        sum  = one;
        term = one;
        for (int i = 1; i <= 14; i++)
        begin
            term = udiv64((term * z) >> 30, 64'(i));
            sum  = sum + term;
        end
        r = udiv64(64'd1 << 60, sum);
        for (int i = 0; i < 4; i++)
        begin
            r = (r * r + (64'd1 << 29)) >> 30;
        end
        if (r > one)
        begin
            r = one;
        end
        q = udiv64(((one - r) << 15) + ((one + r) >> 1), one + r);
        return q[15:0];
    endfunction

endpackage

`default_nettype wire

[sv/gelu_fb_in_if.sv]
// Input channel of the GELU core: valid/ready handshake with mode, x and gradient.
// No dependencies.
`default_nettype none

interface gelu_fb_in_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] x_value;
    logic signed [DATA_WIDTH-1:0] grad_value;

    modport source (output valid, output mode, output x_value, output grad_value, input ready);
    modport sink   (input valid, input mode, input x_value, input grad_value, output ready);
endinterface

`default_nettype wire

[sv/gelu_fb_out_if.sv]
// Result channel of the GELU core: valid/ready handshake with value and clip flag.
// No dependencies.
`default_nettype none

interface gelu_fb_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result_value;
    logic                         saturated;

    modport source (output valid, output result_value, output saturated, input ready);
    modport sink   (input valid, input result_value, input saturated, output ready);
endinterface

`default_nettype wire

[sv/gelu_fb_tanh.sv]
// Three-stage tanh unit: table index, table read, linear interpolation.
// Depends on gelu_fb_pkg (table builder, constants, stage-advance bundle).
`default_nettype none

module gelu_fb_tanh
    import gelu_fb_pkg::*;
#(
    parameter int TANH_TABLE_ENTRIES = 256
)
(
    input  wire logic        clk,
    input  wire tanh_adv_t   adv,
    input  wire logic [16:0] u,     // |argument|, Q.12
    output logic      [15:0] ta     // |tanh|, Q.15
);

    localparam int TW = $clog2(TANH_TABLE_ENTRIES + 1);
    localparam int PW = 14 + TW;

    logic [15:0] tab [0:TANH_TABLE_ENTRIES];

    for (genvar k = 0; k <= TANH_TABLE_ENTRIES; k++)
    begin : g_tab
        localparam logic [15:0] ENTRY = tanh_entry(k, TANH_TABLE_ENTRIES);
        assign tab[k] = ENTRY;
    end

    // Index stage
    logic [PW-1:0] pos_next;
    logic [TW-1:0] idx_reg;
    logic [13:0]   frac_a_reg;
    logic          big_a_reg;

    assign pos_next = PW'(u[13:0]) * PW'(TANH_TABLE_ENTRIES);

    // Table stage
    logic [15:0] lo_reg;
    logic [15:0] hi_reg;
    logic [13:0] frac_b_reg;
    logic        big_b_reg;

    // Interpolation stage
    logic signed [16:0] diff;
    logic signed [31:0] num;
    logic        [31:0] num_mag;
    logic        [17:0] q_mag;
    logic        [17:0] ta_sum;
    logic        [15:0] ta_next;
    logic        [15:0] ta_reg;

    always_comb
    begin
        diff    = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
        num     = 32'(diff) * $signed({18'b0, frac_b_reg}) + 32'sd8192;
        num_mag = num[31] ? 32'(-num) : 32'(num);
        q_mag   = num_mag[31:14];
        ta_sum  = num[31] ? 18'(lo_reg) - q_mag : 18'(lo_reg) + q_mag;
        ta_next = big_b_reg ? TANH_ONE_Q15 : ta_sum[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.idx)
        begin
            idx_reg    <= pos_next[PW-1:14];
            frac_a_reg <= pos_next[13:0];
            big_a_reg  <= (u >= U_LIMIT_Q12);
        end
        if (adv.tab)
        begin
            lo_reg     <= tab[idx_reg];
            hi_reg     <= tab[idx_reg + 1'b1];
            frac_b_reg <= frac_a_reg;
            big_b_reg  <= big_a_reg;
        end
        if (adv.ta)
        begin
            ta_reg <= ta_next;
        end
    end

    assign ta = ta_reg;

endmodule

`default_nettype wire

[sv/gelu_activation_forward_backward_core.sv]
// GELU core, tanh approximation: forward value 0.5*x*(1+tanh(u)) or backward product
// grad*GELU'(x), in signed Q.12, saturated, with a clip flag on each result item.
// The block is a fifteen-stage pipeline that takes one item per clock while the result
// side keeps up. The stages follow the chain of dependent multiplies: x^2, x^3, the tanh
// argument, the table index, the table read, interpolation, 1-tanh^2, two derivative
// products and the final gradient product, each behind its own register. Every stage
// has a valid bit and loads when it is empty or when the stage after it moves, so empty
// slots close up and the input keeps accepting items while a finished result waits at
// the output. Ready on the input side falls only when all fifteen stages hold items.
// There is no clearing pass and no state beyond the pipeline; the tanh table is a
// constant built at elaboration (TANH_TABLE_ENTRIES+1 points of tanh over [0,4]).
// Depends on gelu_fb_pkg, gelu_fb_in_if, gelu_fb_out_if and gelu_fb_tanh.
`default_nettype none

module gelu_activation_forward_backward_core
    import gelu_fb_pkg::*;
#(
    parameter int TANH_TABLE_ENTRIES = 256,
    parameter int DATA_WIDTH         = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gelu_fb_in_if.sink     operand,
    gelu_fb_out_if.source  result
);

    // Stage numbers
    localparam int ST_IN      = 0;   // sign, clipped magnitude
    localparam int ST_SQ      = 1;   // x^2, 0.044715*x, sqrt(2/pi)*x
    localparam int ST_CUBE    = 2;   // x^3 term, polynomial product
    localparam int ST_INNER   = 3;   // x + 0.044715 x^3, 1 + 3*0.044715 x^2
    localparam int ST_U       = 4;   // tanh argument
    localparam int ST_TIDX    = 5;
    localparam int ST_TTAB    = 6;
    localparam int ST_TANH    = 7;
    localparam int ST_SECH    = 8;   // 1+tanh, 1-tanh^2
    localparam int ST_M2      = 9;   // derivative product, forward product
    localparam int ST_T2      = 10;
    localparam int ST_D       = 11;  // derivative
    localparam int ST_PROD    = 12;
    localparam int ST_RND     = 13;
    localparam int ST_OUT     = 14;
    localparam int NUM_STAGES = 15;

    localparam int FW = DATA_WIDTH + 18;   // forward product
    localparam int PW = DATA_WIDTH + 26;   // selected product
    localparam int RW = PW - 15;           // rounded magnitude

    localparam logic [RW-1:0] POS_LIMIT = RW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [RW-1:0] NEG_LIMIT = RW'(64'd1 << (DATA_WIDTH - 1));
    localparam logic signed [DATA_WIDTH-1:0] RES_MAX = DATA_WIDTH'(POS_LIMIT);
    localparam logic signed [DATA_WIDTH-1:0] RES_MIN = DATA_WIDTH'(NEG_LIMIT);

    typedef struct packed
    {
        mode_t                        mode;
        logic signed [DATA_WIDTH-1:0] x_value;
        logic signed [DATA_WIDTH-1:0] grad_value;
    } carry_t;

    // Handshake: a stage loads when it is empty or its successor moves
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   en;

    assign en[NUM_STAGES] = result.ready;
    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_en
        assign en[s] = ~vld_reg[s] | en[s + 1];
    end

    assign operand.ready = en[ST_IN];
    assign result.valid  = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[ST_IN])
            begin
                vld_reg[ST_IN] <= operand.valid;
            end
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                if (en[s])
                begin
                    vld_reg[s] <= vld_reg[s - 1];
                end
            end
        end
    end

    // Payload registers and delay lines
    carry_t                  carry_reg  [ST_IN:ST_D];
    logic [15:0]             ac_reg     [ST_IN:ST_CUBE];
    logic [18:0]             m1_reg     [ST_SQ:ST_SECH];
    logic [19:0]             poly_reg   [ST_INNER:ST_M2];
    logic [16:0]             onept_reg  [ST_SECH:ST_T2];
    logic signed [FW-1:0]    pf_reg     [ST_M2:ST_D];
    logic [30:0]             sq_reg;
    logic [26:0]             k1_reg;
    logic [57:0]             c40_reg;
    logic [43:0]             praw_reg;
    logic [16:0]             inner_reg;
    logic [16:0]             u_reg;
    logic [30:0]             sech2_reg;
    logic [19:0]             m2_reg;
    logic [23:0]             t2_reg;
    logic signed [25:0]      d_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [RW-1:0]           rmag_reg;
    logic                    rneg_reg;
    logic signed [DATA_WIDTH-1:0] result_value_reg;
    logic                    saturated_reg;

    // Next values
    carry_t                  carry_next;
    logic [DATA_WIDTH-1:0]   a_mag;
    logic [32:0]             a_ext;
    logic [15:0]             ac_next;
    logic [31:0]             sq_next;
    logic [27:0]             k1_next;
    logic [31:0]             m1_next;
    logic [57:0]             c40_next;
    logic [43:0]             praw_next;
    logic [57:0]             c_round;
    logic [17:0]             inner_next;
    logic [43:0]             p_round;
    logic [19:0]             poly_next;
    logic [32:0]             u_next;
    logic [15:0]             ta;
    logic [16:0]             onept_next;
    logic [31:0]             ta_sq;
    logic [30:0]             sech2_next;
    logic [49:0]             m2_next;
    logic signed [FW-1:0]    pf_next;
    logic [39:0]             m3_next;
    logic [24:0]             t2_next;
    logic signed [25:0]      d_next;
    logic signed [PW-1:0]    prod_next;
    logic [PW-1:0]           prod_mag;
    logic [PW:0]             rsum;
    logic signed [DATA_WIDTH-1:0] result_value_next;
    logic                    saturated_next;
    tanh_adv_t               tanh_adv;

    always_comb
    begin
        // Input stage: magnitude of x, clipped at 8.0 for the tanh argument
        carry_next.mode       = mode_t'(operand.mode);
        carry_next.x_value    = operand.x_value;
        carry_next.grad_value = operand.grad_value;
        a_mag   = operand.x_value[DATA_WIDTH-1] ? $unsigned(-operand.x_value)
                                                : $unsigned(operand.x_value);
        a_ext   = 33'(a_mag);
        ac_next = (a_ext > 33'(X_CAP_Q12)) ? X_CAP_Q12 : a_ext[15:0];

        // Three independent products of |x|
        sq_next = 32'(ac_reg[ST_IN]) * 32'(ac_reg[ST_IN]);
        k1_next = 28'(ac_reg[ST_IN]) * 28'(CUBIC_Q16);
        m1_next = 32'(ac_reg[ST_IN]) * 32'(SQRT_2_PI_Q16) + 32'd2048;

        // x^3 * 0.044715 and x^2 * 3*0.044715
        c40_next  = 58'(sq_reg) * 58'(k1_reg);
        praw_next = 44'(sq_reg) * 44'(CUBIC3_Q16);

        // Round and add
        c_round    = c40_reg + (58'd1 << 39);
        inner_next = 18'(ac_reg[ST_CUBE]) + c_round[57:40];
        p_round    = praw_reg + (44'd1 << 23);
        poly_next  = 20'd65536 + p_round[43:24];

        // tanh argument
        u_next = 33'(inner_reg) * 33'(SQRT_2_PI_Q16) + 33'd32768;

        // 1+tanh with the sign of x, and 1-tanh^2 (zero where tanh saturates)
        onept_next = carry_reg[ST_TANH].x_value[DATA_WIDTH-1] ? HALF_Q16 - 17'(ta)
                                                              : HALF_Q16 + 17'(ta);
        ta_sq      = 32'(ta) * 32'(ta);
        sech2_next = 31'(32'd1 << 30) - ta_sq[30:0];

        m2_next = 50'(m1_reg[ST_SECH]) * 50'(sech2_reg) + (50'd1 << 29);
        pf_next = FW'(carry_reg[ST_SECH].x_value) * FW'($signed({1'b0, onept_reg[ST_SECH]}));

        m3_next = 40'(m2_reg) * 40'(poly_reg[ST_M2]) + 40'd32768;
        t2_next = 25'(m3_next[39:16]) + 25'd1;

        d_next = carry_reg[ST_T2].x_value[DATA_WIDTH-1]
               ? 26'(onept_reg[ST_T2]) - 26'(t2_reg)
               : 26'(onept_reg[ST_T2]) + 26'(t2_reg);

        prod_next = (carry_reg[ST_D].mode == MODE_BACKWARD)
                  ? PW'(carry_reg[ST_D].grad_value) * PW'(d_reg)
                  : PW'(pf_reg[ST_D]);

        // Round half away from zero on the magnitude
        prod_mag = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
        rsum     = {1'b0, prod_mag} + (PW + 1)'(32768);

        // Saturate to the signed result range
        priority if (!rneg_reg && (rmag_reg > POS_LIMIT))
        begin
            result_value_next = RES_MAX;
            saturated_next    = 1'b1;
        end
        else if (rneg_reg && (rmag_reg > NEG_LIMIT))
        begin
            result_value_next = RES_MIN;
            saturated_next    = 1'b1;
        end
        else if (rneg_reg)
        begin
            result_value_next = DATA_WIDTH'(RW'(0) - rmag_reg);
            saturated_next    = 1'b0;
        end
        else
        begin
            result_value_next = DATA_WIDTH'(rmag_reg);
            saturated_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            carry_reg[ST_IN] <= carry_next;
            ac_reg[ST_IN]    <= ac_next;
        end
        for (int s = ST_IN + 1; s <= ST_D; s++)
        begin
            if (en[s])
            begin
                carry_reg[s] <= carry_reg[s - 1];
            end
        end
        for (int s = ST_IN + 1; s <= ST_CUBE; s++)
        begin
            if (en[s])
            begin
                ac_reg[s] <= ac_reg[s - 1];
            end
        end

        if (en[ST_SQ])
        begin
            sq_reg        <= sq_next[30:0];
            k1_reg        <= k1_next[26:0];
            m1_reg[ST_SQ] <= m1_next[30:12];
        end
        for (int s = ST_SQ + 1; s <= ST_SECH; s++)
        begin
            if (en[s])
            begin
                m1_reg[s] <= m1_reg[s - 1];
            end
        end

        if (en[ST_CUBE])
        begin
            c40_reg  <= c40_next;
            praw_reg <= praw_next;
        end

        if (en[ST_INNER])
        begin
            inner_reg          <= inner_next[16:0];
            poly_reg[ST_INNER] <= poly_next;
        end
        for (int s = ST_INNER + 1; s <= ST_M2; s++)
        begin
            if (en[s])
            begin
                poly_reg[s] <= poly_reg[s - 1];
            end
        end

        if (en[ST_U])
        begin
            u_reg <= u_next[32:16];
        end

        if (en[ST_SECH])
        begin
            onept_reg[ST_SECH] <= onept_next;
            sech2_reg          <= sech2_next;
        end
        for (int s = ST_SECH + 1; s <= ST_T2; s++)
        begin
            if (en[s])
            begin
                onept_reg[s] <= onept_reg[s - 1];
            end
        end

        if (en[ST_M2])
        begin
            m2_reg           <= m2_next[49:30];
            pf_reg[ST_M2]    <= pf_next;
        end
        for (int s = ST_M2 + 1; s <= ST_D; s++)
        begin
            if (en[s])
            begin
                pf_reg[s] <= pf_reg[s - 1];
            end
        end

        if (en[ST_T2])
        begin
            t2_reg <= t2_next[24:1];
        end
        if (en[ST_D])
        begin
            d_reg <= d_next;
        end
        if (en[ST_PROD])
        begin
            prod_reg <= prod_next;
        end
        if (en[ST_RND])
        begin
            rmag_reg <= rsum[PW:16];
            rneg_reg <= prod_reg[PW-1];
        end
        if (en[ST_OUT])
        begin
            result_value_reg <= result_value_next;
            saturated_reg    <= saturated_next;
        end
    end

    assign result.result_value = result_value_reg;
    assign result.saturated    = saturated_reg;

    // tanh lookup and interpolation, stages ST_TIDX to ST_TANH
    assign tanh_adv.idx = en[ST_TIDX];
    assign tanh_adv.tab = en[ST_TTAB];
    assign tanh_adv.ta  = en[ST_TANH];

    gelu_fb_tanh #(
        .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
    ) u_tanh (
        .clk (clk),
        .adv (tanh_adv),
        .u   (u_reg),
        .ta  (ta)
    );

    // A clipped result sits at one end of the range
    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            (result.result_value == RES_MAX) || (result.result_value == RES_MIN))
        else $error("saturated result not at range limit");

    // Input back-pressure only when every stage is occupied
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !operand.ready |-> (&vld_reg))
        else $error("input stalled with an empty stage");

    // A taken item occupies the first stage on the next edge
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        operand.valid && operand.ready |=> vld_reg[ST_IN])
        else $error("accepted item lost at input stage");

    // tanh magnitude never exceeds one
    a_ta_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_TANH] |-> (ta <= TANH_ONE_Q15))
        else $error("tanh magnitude above one");

    // Output drains when delivered and nothing follows
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !vld_reg[ST_RND] |=> !result.valid)
        else $error("result repeated after delivery");

endmodule

`default_nettype wire

[tb/sv/gelu_fb_result_checker.sv]
// Scoreboard for the GELU forward/backward core: watches both channels, computes each
// expected result in fixed point and compares it with what the core returns.
// Depends on gelu_fb_pkg, gelu_fb_in_if and gelu_fb_out_if.
`timescale 1ns / 100ps

module gelu_fb_result_checker
    import gelu_fb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gelu_fb_in_if      operand,
    gelu_fb_out_if     result,
    output int         mismatch_count,
    output int         pending_count
);

    localparam int     TANH_POINTS   = 256;
    localparam longint SQRT2PI_Q16   = 52290;
    localparam longint CUBE_COEF_Q16 = 2930;
    localparam longint SLOPE_COEF_Q16 = 8791;
    localparam longint ARG_LIMIT_Q12 = 16384;
    localparam longint X_CLAMP_Q12   = 32768;
    localparam longint ONE_Q15       = 32768;
    localparam longint ONE_Q16       = 65536;
    localparam longint RESULT_MAX    = 32767;
    localparam longint RESULT_MIN    = -32768;
    localparam int     REPORT_LIMIT  = 10;

    typedef struct packed
    {
        logic signed [15:0] value;
        logic               clipped;
    } gelu_out_t;

    longint    tanh_q15_points [0:TANH_POINTS];
    gelu_out_t pending_gelu_results [$];
    int        results_seen;

    // tanh(4k/N) in Q.15: exp(-z) from a degree-14 series and a reciprocal, raised to
    // the 16th power by squaring, then (1-r)/(1+r) rounded
    initial
    begin
        longint unsigned unity;
        longint unsigned z;
        longint unsigned series;
        longint unsigned term;
        longint unsigned r;
        unity = 64'd1 << 30;
        for (int k = 0; k <= TANH_POINTS; k++)
        begin
            z      = (64'(k) << 29) / 64'(TANH_POINTS);
            series = unity;
            term   = unity;
            for (int i = 1; i <= 14; i++)
            begin
                term   = ((term * z) >> 30) / 64'(i);
                series = series + term;
            end
            r = (64'd1 << 60) / series;
            for (int i = 0; i < 4; i++)
            begin
                r = (r * r + (64'd1 << 29)) >> 30;
            end
            if (r > unity)
            begin
                r = unity;
            end
            tanh_q15_points[k] = longint'((((unity - r) << 15) + ((unity + r) >> 1))
                                          / (unity + r));
        end
    end

    // Round a product to Q.12, half away from zero
    function automatic longint round_away(input longint v, input int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 << (sh - 1))) >> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    // tanh magnitude in Q.15 for a non-negative argument in Q.12
    function automatic longint tanh_lookup(input longint arg);
        longint p;
        longint idx;
        longint frac;
        longint lo;
        longint hi;
        if (arg >= ARG_LIMIT_Q12)
        begin
            return ONE_Q15;
        end
        p    = arg * TANH_POINTS;
        idx  = p >> 14;
        frac = p & 64'sd16383;
        if (idx >= TANH_POINTS)
        begin
            return ONE_Q15;
        end
        lo = tanh_q15_points[idx];
        hi = tanh_q15_points[idx + 1];
        return lo + ((hi - lo) * frac + 8192) / 16384;
    endfunction

    // GELU(x) or grad*GELU'(x), worked on |x| with the sign restored by odd symmetry
    function automatic gelu_out_t gelu_q12(input logic m, input logic signed [15:0] x_in,
                                           input logic signed [15:0] g_in);
        gelu_out_t out;
        longint    x;
        longint    g;
        longint    ac;
        longint    inner;
        longint    arg;
        longint    ta;
        longint    onept;
        longint    d;
        longint    sech2;
        longint    poly;
        longint    m1;
        longint    m2;
        longint    m3;
        longint    half_term;
        longint    res;
        logic      neg;
        x     = x_in;
        g     = g_in;
        neg   = (x < 0);
        ac    = neg ? -x : x;
        if (ac > X_CLAMP_Q12)
        begin
            ac = X_CLAMP_Q12;
        end
        inner = ac + ((ac * ac * ac * CUBE_COEF_Q16 + (64'sd1 << 39)) >> 40);
        arg   = (inner * SQRT2PI_Q16 + 32768) >> 16;
        ta    = tanh_lookup(arg);
        onept = ONE_Q15 + (neg ? -ta : ta);
        if (mode_t'(m) == MODE_FORWARD)
        begin
            res = round_away(x * onept, 16);
        end
        else
        begin
            d = onept;
            // with tanh pinned at one the sech^2 term vanishes
            if (arg < ARG_LIMIT_Q12)
            begin
                sech2     = (64'sd1 << 30) - ta * ta;
                poly      = ONE_Q16 + ((ac * ac * SLOPE_COEF_Q16 + (64'sd1 << 23)) >> 24);
                m1        = (ac * SQRT2PI_Q16 + 2048) >> 12;
                m2        = (m1 * sech2 + (64'sd1 << 29)) >> 30;
                m3        = (m2 * poly + 32768) >> 16;
                half_term = (m3 + 1) >> 1;
                d         = d + (neg ? -half_term : half_term);
            end
            res = round_away(g * d, 16);
        end
        out.clipped = 1'b0;
        if (res > RESULT_MAX)
        begin
            res         = RESULT_MAX;
            out.clipped = 1'b1;
        end
        else if (res < RESULT_MIN)
        begin
            res         = RESULT_MIN;
            out.clipped = 1'b1;
        end
        out.value = res[15:0];
        return out;
    endfunction

    task automatic note_mismatch(input string detail);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%t gelu check: %s", $realtime, detail);
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
        results_seen   = 0;
    end

    // Retire the result first, then queue the prediction for a newly taken item
    always @(posedge clk)
    begin : watch
        gelu_out_t want;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (pending_gelu_results.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result %0d: value %0d clip %0b",
                                            results_seen, result.result_value,
                                            result.saturated));
                end
                else
                begin
                    want = pending_gelu_results.pop_front();
                    if (want.value !== result.result_value || want.clipped !== result.saturated)
                    begin
                        note_mismatch($sformatf(
                            "result %0d: expected value %0d clip %0b, got value %0d clip %0b",
                            results_seen, want.value, want.clipped,
                            result.result_value, result.saturated));
                    end
                end
                results_seen++;
            end
            if (operand.valid && operand.ready)
            begin
                pending_gelu_results.push_back(gelu_q12(operand.mode, operand.x_value,
                                                        operand.grad_value));
            end
        end
        pending_count <= pending_gelu_results.size();
    end

endmodule

[tb/sv/tb_gelu_activation_forward_backward_core.sv]
// Top of the GELU core testbench: clock, reset, item stimulus on the operand channel and
// random back-pressure on the result channel; checking lives in gelu_fb_result_checker.
// Depends on gelu_fb_pkg, both channel interfaces, the core and the checker.
`timescale 1ns / 100ps

module tb_gelu_activation_forward_backward_core;
    import gelu_fb_pkg::*;

    // Slowest correct run is far below this: 1023 items, each behind at most the longest
    // idle_cycles() sender gap or receiver stall, plus one HOLDOFF_CYCLES hold-off.
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int HOLDOFF_AFTER  = 60;
    localparam int DRAIN_CYCLES   = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   mismatch_count;
    int   pending_count;
    int   items_sent;
    int   cycle_count;
    logic sender_gaps;
    logic holdoff_done;

    gelu_fb_in_if  #(.DATA_WIDTH(16)) operand_ch ();
    gelu_fb_out_if #(.DATA_WIDTH(16)) result_ch ();

    gelu_activation_forward_backward_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .result  (result_ch)
    );

    gelu_fb_result_checker scoreboard
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .operand        (operand_ch),
        .result         (result_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then a long gap
    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            return 0;
        end
        if (pick < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // Activation: mostly full range or the curved region |x| < 4.0, some tiny values and
    // some hugging either end of the Q4.12 range
    function automatic logic [15:0] pick_activation();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            return 16'($urandom);
        end
        if (pick < 8)
        begin
            return 16'($urandom_range(0, 32767)) - 16'd16384;
        end
        if (pick < 9)
        begin
            return 16'($urandom_range(0, 127)) - 16'd64;
        end
        return ($urandom_range(0, 1) != 0) ? 16'h7fff - 16'($urandom_range(0, 15))
                                            : 16'h8000 + 16'($urandom_range(0, 15));
    endfunction

    // Gradient: full range to provoke clipping, a moderate band, and the extremes
    function automatic logic [15:0] pick_gradient();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            return 16'($urandom);
        end
        if (pick < 8)
        begin
            return 16'($urandom_range(0, 16383)) - 16'd8192;
        end
        return ($urandom_range(0, 1) != 0) ? 16'h7fff - 16'($urandom_range(0, 7))
                                            : 16'h8000 + 16'($urandom_range(0, 7));
    endfunction

    // Offer one item and hold it until the core takes it. Called at a rising edge;
    // returns at the edge where the item was accepted, with valid still high so a
    // back-to-back item follows without a bubble.
    task automatic offer_activation(input mode_t m, input logic [15:0] x,
                                    input logic [15:0] g);
        int gap;
        gap = sender_gaps ? idle_cycles() : 0;
        if (gap > 0)
        begin
            operand_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand_ch.valid      <= 1'b1;
        operand_ch.mode       <= m;
        operand_ch.x_value    <= x;
        operand_ch.grad_value <= g;
        do
        begin
            @(posedge clk);
        end
        while (!operand_ch.ready);
        items_sent++;
    endtask

    // Stimulus: reset, directed corners, then random items
    initial
    begin
        operand_ch.valid      = 1'b0;
        operand_ch.mode       = MODE_FORWARD;
        operand_ch.x_value    = '0;
        operand_ch.grad_value = '0;
        items_sent            = 0;
        sender_gaps           = 1'b1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Forward value at zero, unit steps, both ends of the range (the negative end
        // sits right at the 8.0 clamp of the tanh argument) and one and minus one
        offer_activation(MODE_FORWARD, 16'h0000, 16'h0000);
        offer_activation(MODE_FORWARD, 16'h7fff, 16'h0000);
        offer_activation(MODE_FORWARD, 16'h8000, 16'h0000);
        offer_activation(MODE_FORWARD, 16'h0001, 16'h0000);
        offer_activation(MODE_FORWARD, 16'hffff, 16'h0000);
        offer_activation(MODE_FORWARD, 16'd4096, 16'h0000);
        offer_activation(MODE_FORWARD, -16'sd4096, 16'h0000);
        // Around the point where the tanh argument reaches 4.0 and tanh pins at one
        offer_activation(MODE_FORWARD, 16'd13660, 16'h0000);
        offer_activation(MODE_FORWARD, 16'd13700, 16'h0000);
        offer_activation(MODE_FORWARD, -16'sd13700, 16'h0000);
        offer_activation(MODE_FORWARD, 16'd12288, 16'h5555);
        // Backward product: zero activation, slope above one that clips both ways
        offer_activation(MODE_BACKWARD, 16'h0000, 16'h7fff);
        offer_activation(MODE_BACKWARD, 16'd4096, 16'h7fff);
        offer_activation(MODE_BACKWARD, 16'd4096, 16'h8000);
        offer_activation(MODE_BACKWARD, 16'd6144, 16'h7fff);
        offer_activation(MODE_BACKWARD, -16'sd4096, 16'h7fff);
        // Saturated tanh on both sides: derivative exactly one or exactly zero
        offer_activation(MODE_BACKWARD, 16'h7fff, 16'h8000);
        offer_activation(MODE_BACKWARD, 16'h8000, 16'h7fff);
        offer_activation(MODE_BACKWARD, 16'd12288, 16'h7fff);
        offer_activation(MODE_BACKWARD, 16'd13680, 16'd20000);
        offer_activation(MODE_BACKWARD, 16'd2048, 16'hffff);
        offer_activation(MODE_BACKWARD, -16'sd2048, 16'h0001);
        offer_activation(MODE_BACKWARD, 16'h0001, 16'h8000);

        // Random part. The first stretch runs without gaps so that the receiver's long
        // hold-off finds the sender pushing and the pipeline fills and stalls its input;
        // later stretches alternate between gaps and none.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sender_gaps = (n >= 150) && (((n / 100) % 3) != 0);
            offer_activation(($urandom_range(0, 1) != 0) ? MODE_BACKWARD : MODE_FORWARD,
                             pick_activation(), pick_gradient());
        end
        operand_ch.valid <= 1'b0;

        // Drain: wait for every prediction to be matched, then watch for stray results
        do
        begin
            @(posedge clk);
        end
        while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("tb_gelu_activation_forward_backward_core: PASS");
        end
        else
        begin
            $display("tb_gelu_activation_forward_backward_core: FAIL");
        end
        $finish;
    end

    // Result side: random stalls and ready stretches, with one long hold-off once the
    // random part is under way
    initial
    begin
        int hold;
        result_ch.ready = 1'b0;
        holdoff_done    = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!holdoff_done && items_sent >= HOLDOFF_AFTER)
            begin
                holdoff_done = 1'b1;
                hold         = HOLDOFF_CYCLES;
            end
            else
            begin
                hold = idle_cycles();
            end
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(50, 100)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_gelu_activation_forward_backward_core: FAIL");
        $finish;
    end

endmodule
